// File: sv/mm3_pkg.sv
// ----------------------------------------------------------------------------
// mm3_pkg
// Shared types and constants for the 3x3 fixed-point matrix multiplier.
// ----------------------------------------------------------------------------
package mm3_pkg;

  localparam int DIM_DEF       = 3;
  localparam int ELEM_BITS_DEF = 16;
  localparam int PRODUCT_BITS  = 33;
  localparam int IDX_BITS      = 2;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_RUN,
    ST_DRAIN
  } mm3_state_t;

  typedef struct packed {
    logic wr_a;
    logic wr_b;
    logic rd;
    logic first;
    logic last;
    logic fin;
  } mm3_cmd_t;

  typedef struct packed {
    logic done;
  } mm3_status_t;

endpackage

// File: sv/mm3_ram.sv
// ----------------------------------------------------------------------------
// mm3_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mm3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 9
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/mm3_ctrl.sv
// ----------------------------------------------------------------------------
// mm3_ctrl
// Controller: counts loaded words and sequences the row, column and inner
// index of the product.
// ----------------------------------------------------------------------------
module mm3_ctrl #(
  parameter int DIM = 3
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  mm3_pkg::mm3_status_t              status,
  output mm3_pkg::mm3_cmd_t                 cmd,
  output logic [$clog2(DIM*DIM)-1:0]        wr_addr,
  output logic [$clog2(DIM*DIM)-1:0]        rd_a_addr,
  output logic [$clog2(DIM*DIM)-1:0]        rd_b_addr,
  output logic [$clog2(DIM)-1:0]            row,
  output logic [$clog2(DIM)-1:0]            col
);
  import mm3_pkg::*;

  localparam int N  = DIM * DIM;
  localparam int AW = $clog2(N);
  localparam int CW = $clog2(2 * N);
  localparam int IW = $clog2(DIM);

  mm3_state_t    state, state_next;
  logic [CW-1:0] count;
  logic [IW-1:0] k;
  logic          load_en;
  logic          in_a;
  logic          last_load;
  logic          k_end, j_end, i_end;
  logic [CW-1:0] b_off;

  assign load_en   = (state == ST_LOAD) && start;
  assign in_a      = count < CW'(N);
  assign last_load = count == CW'(2 * N - 1);
  assign b_off     = count - CW'(N);
  assign k_end     = k == IW'(DIM - 1);
  assign j_end     = col == IW'(DIM - 1);
  assign i_end     = row == IW'(DIM - 1);

  assign busy      = state != ST_LOAD;
  assign wr_addr   = in_a ? count[AW-1:0] : b_off[AW-1:0];
  assign rd_a_addr = AW'(int'(row) * DIM + int'(k));
  assign rd_b_addr = AW'(int'(k) * DIM + int'(col));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_LOAD: begin
        cmd.wr_a = load_en && in_a;
        cmd.wr_b = load_en && !in_a;
        if (load_en && last_load) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.rd    = 1'b1;
        cmd.first = k == '0;
        cmd.last  = k_end;
        cmd.fin   = k_end && j_end && i_end;
        if (k_end && j_end && i_end) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (status.done) begin
          state_next = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      k     <= '0;
      row   <= '0;
      col   <= '0;
    end else begin
      if (load_en) begin
        count <= last_load ? '0 : count + 1'b1;
      end
      if (state == ST_RUN) begin
        if (k_end) begin
          k <= '0;
          if (j_end) begin
            col <= '0;
            row <= i_end ? '0 : row + 1'b1;
          end else begin
            col <= col + 1'b1;
          end
        end else begin
          k <= k + 1'b1;
        end
      end
    end
  end

endmodule

// File: sv/mm3_dp.sv
// ----------------------------------------------------------------------------
// mm3_dp
// Datapath: element stores, multiplier and accumulator, result registers.
// ----------------------------------------------------------------------------
module mm3_dp #(
  parameter int DIM       = 3,
  parameter int ELEM_BITS = 16
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic signed [ELEM_BITS-1:0]              elem_value,
  input  mm3_pkg::mm3_cmd_t                        cmd,
  input  logic [$clog2(DIM*DIM)-1:0]               wr_addr,
  input  logic [$clog2(DIM*DIM)-1:0]               rd_a_addr,
  input  logic [$clog2(DIM*DIM)-1:0]               rd_b_addr,
  input  logic [$clog2(DIM)-1:0]                   row,
  input  logic [$clog2(DIM)-1:0]                   col,
  output mm3_pkg::mm3_status_t                     status,
  output logic                                     result_strobe,
  output logic signed [mm3_pkg::PRODUCT_BITS-1:0]  product_value,
  output logic [mm3_pkg::IDX_BITS-1:0]             out_row,
  output logic [mm3_pkg::IDX_BITS-1:0]             out_col,
  output logic                                     last_entry
);
  import mm3_pkg::*;

  localparam int N     = DIM * DIM;
  localparam int IW    = $clog2(DIM);
  localparam int PW    = 2 * ELEM_BITS;
  localparam int EXT_W = PW + PRODUCT_BITS;

  logic [ELEM_BITS-1:0]          a_data, b_data;
  logic                          s1_valid, s1_first, s1_last, s1_fin;
  logic [IW-1:0]                 s1_row, s1_col;
  logic                          s2_valid, s2_first, s2_last, s2_fin;
  logic [IW-1:0]                 s2_row, s2_col;
  logic signed [PW-1:0]          prod;
  logic signed [EXT_W-1:0]       prod_ext;
  logic [PRODUCT_BITS-1:0]       term;
  logic [PRODUCT_BITS-1:0]       acc, acc_next;
  logic [IW+IDX_BITS-1:0]        row_ext, col_ext;

  mm3_ram #(.WIDTH(ELEM_BITS), .DEPTH(N)) u_store_a (
    .clk   (clk),
    .we    (cmd.wr_a),
    .waddr (wr_addr),
    .wdata (elem_value),
    .raddr (rd_a_addr),
    .rdata (a_data)
  );

  mm3_ram #(.WIDTH(ELEM_BITS), .DEPTH(N)) u_store_b (
    .clk   (clk),
    .we    (cmd.wr_b),
    .waddr (wr_addr),
    .wdata (elem_value),
    .raddr (rd_b_addr),
    .rdata (b_data)
  );

  assign prod_ext = EXT_W'(prod);
  assign term     = prod_ext[PRODUCT_BITS-1:0];
  assign acc_next = s2_first ? term : acc + term;
  assign row_ext  = (IW + IDX_BITS)'(s2_row);
  assign col_ext  = (IW + IDX_BITS)'(s2_col);

  assign status.done = result_strobe && last_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      s1_valid      <= cmd.rd;
      s2_valid      <= s1_valid;
      result_strobe <= s2_valid && s2_last;
    end
  end

  always_ff @(posedge clk) begin
    s1_first <= cmd.first;
    s1_last  <= cmd.last;
    s1_fin   <= cmd.fin;
    s1_row   <= row;
    s1_col   <= col;

    s2_first <= s1_first;
    s2_last  <= s1_last;
    s2_fin   <= s1_fin;
    s2_row   <= s1_row;
    s2_col   <= s1_col;
    prod     <= $signed(a_data) * $signed(b_data);

    if (s2_valid) begin
      acc <= acc_next;
    end
    if (s2_valid && s2_last) begin
      product_value <= $signed(acc_next);
      out_row       <= row_ext[IDX_BITS-1:0];
      out_col       <= col_ext[IDX_BITS-1:0];
      last_entry    <= s2_fin;
    end
  end

endmodule

// File: sv/matrix_multiply_3x3.sv
// ----------------------------------------------------------------------------
// matrix_multiply_3x3
// Streaming DIM x DIM signed fixed-point matrix product C = A * B.
// ----------------------------------------------------------------------------
// Load 2*DIM*DIM words on elem_value, one per cycle with start high while
// busy is low: matrix A row-major, then matrix B row-major. The word that
// completes B raises busy; the block then steps one multiply-accumulate per
// cycle through the store read port, with the single shared multiplier and
// the read, multiply and accumulate pipeline, and busy stays high until the
// final entry of C is out. The DIM*DIM entries of C come out in row-major
// order, each for one cycle with result_strobe high; last_entry marks the
// final one.
// The receiver cannot stall: take every word while result_strobe is high.
// Entries are exact Q16.16 sums, truncated to 33 bits.
// ----------------------------------------------------------------------------
module matrix_multiply_3x3 #(
  parameter int DIM       = mm3_pkg::DIM_DEF,
  parameter int ELEM_BITS = mm3_pkg::ELEM_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     start,
  output logic                                     busy,
  input  logic signed [ELEM_BITS-1:0]              elem_value,
  output logic                                     result_strobe,
  output logic signed [mm3_pkg::PRODUCT_BITS-1:0]  product_value,
  output logic [mm3_pkg::IDX_BITS-1:0]             out_row,
  output logic [mm3_pkg::IDX_BITS-1:0]             out_col,
  output logic                                     last_entry
);
  import mm3_pkg::*;

  localparam int AW = $clog2(DIM * DIM);
  localparam int IW = $clog2(DIM);

  mm3_cmd_t      cmd;
  mm3_status_t   status;
  logic [AW-1:0] wr_addr, rd_a_addr, rd_b_addr;
  logic [IW-1:0] row, col;

  mm3_ctrl #(.DIM(DIM)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .status    (status),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (rd_b_addr),
    .row       (row),
    .col       (col)
  );

  mm3_dp #(.DIM(DIM), .ELEM_BITS(ELEM_BITS)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .elem_value    (elem_value),
    .cmd           (cmd),
    .wr_addr       (wr_addr),
    .rd_a_addr     (rd_a_addr),
    .rd_b_addr     (rd_b_addr),
    .row           (row),
    .col           (col),
    .status        (status),
    .result_strobe (result_strobe),
    .product_value (product_value),
    .out_row       (out_row),
    .out_col       (out_col),
    .last_entry    (last_entry)
  );

endmodule
